// ===== hdl/rrqs_pkg.sv =====
// Shared types, widths and status codes of the round-robin quantum scheduler.
package rrqs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int TAG_W     = 8;
  localparam int TIME_W    = 16;
  localparam int ROUND_W   = 16;
  localparam int ELAPSED_W = 32;
  localparam int STATUS_W  = 3;

  localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RUNNING    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FINISHED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd5;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] ticks;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hdl/rrqs_slot_mem.sv =====
// Process table: one write port, one read port with registered read data.
module rrqs_slot_mem (
  input  logic              clk,
  input  rrqs_pkg::mem_req_t req,
  output rrqs_pkg::entry_t   rd_data
);

  rrqs_pkg::entry_t mem [rrqs_pkg::MAX_PROCS];
  rrqs_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/rrqs_engine.sv =====
// Sequencer: add/run handling, round counters, read-modify-write of the table, result register.
module rrqs_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [rrqs_pkg::TIME_W-1:0]       quantum,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [rrqs_pkg::TAG_W-1:0]        in_process_id,
  input  logic [rrqs_pkg::TIME_W-1:0]       in_burst_time,
  output rrqs_pkg::mem_req_t                mem_req,
  input  rrqs_pkg::entry_t                  mem_rd,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rrqs_pkg::STATUS_W-1:0]     out_status,
  output logic [rrqs_pkg::TAG_W-1:0]        out_tag_out,
  output logic [rrqs_pkg::TIME_W-1:0]       out_time_left,
  output logic [rrqs_pkg::ROUND_W-1:0]      out_round_number,
  output logic [rrqs_pkg::ELAPSED_W-1:0]    out_elapsed_total,
  output logic                              out_last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                             state_r, state_nxt;
  logic [rrqs_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic [rrqs_pkg::CNT_W-1:0]         n_r, n_nxt;
  logic [rrqs_pkg::CNT_W-1:0]         keep_r, keep_nxt;
  logic [rrqs_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [rrqs_pkg::ROUND_W-1:0]       rounds_r, rounds_nxt;
  logic [rrqs_pkg::ELAPSED_W-1:0]     elapsed_r, elapsed_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_load;
  logic [rrqs_pkg::STATUS_W-1:0]      status_r, status_nxt;
  logic [rrqs_pkg::TAG_W-1:0]         tag_r, tag_nxt;
  logic [rrqs_pkg::TIME_W-1:0]        tleft_r, tleft_nxt;
  logic [rrqs_pkg::ROUND_W-1:0]       round_r, round_nxt;
  logic [rrqs_pkg::ELAPSED_W-1:0]     etot_r, etot_nxt;
  logic                               last_r, last_nxt;

  logic                               out_free;
  logic                               in_acc;
  logic                               fin;
  logic [rrqs_pkg::ELAPSED_W:0]       esum;
  logic [rrqs_pkg::TIME_W-1:0]        nt;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign esum     = {1'b0, elapsed_r} + (rrqs_pkg::ELAPSED_W + 1)'(quantum);
  assign nt       = mem_rd.ticks - quantum;
  assign fin      = (rrqs_pkg::CNT_W'(idx_r) + rrqs_pkg::CNT_W'(1)) == n_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    keep_nxt      = keep_r;
    cnt_nxt       = cnt_r;
    rounds_nxt    = rounds_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    status_nxt    = status_r;
    tag_nxt       = tag_r;
    tleft_nxt     = tleft_r;
    round_nxt     = rounds_r;
    etot_nxt      = elapsed_r;
    last_nxt      = 1'b1;
    mem_req.we    = 1'b0;
    mem_req.waddr = cnt_r[rrqs_pkg::IDX_W-1:0];
    mem_req.wdata = '{tag: in_process_id, ticks: in_burst_time};
    mem_req.raddr = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode == rrqs_pkg::MODE_ADD) begin
            out_load  = 1'b1;
            tag_nxt   = in_process_id;
            tleft_nxt = in_burst_time;
            if (in_burst_time <= quantum) begin
              status_nxt = rrqs_pkg::ST_SHORT;
            end else if (cnt_r >= rrqs_pkg::CNT_W'(rrqs_pkg::MAX_PROCS)) begin
              status_nxt = rrqs_pkg::ST_FULL;
            end else begin
              status_nxt = rrqs_pkg::ST_ADDED;
              mem_req.we = 1'b1;
              cnt_nxt    = cnt_r + rrqs_pkg::CNT_W'(1);
            end
          end else if (cnt_r == '0) begin
            out_load   = 1'b1;
            status_nxt = rrqs_pkg::ST_EMPTY;
            tag_nxt    = '0;
            tleft_nxt  = '0;
          end else begin
            if (rounds_r != '1) begin
              rounds_nxt = rounds_r + rrqs_pkg::ROUND_W'(1);
            end
            elapsed_nxt = esum[rrqs_pkg::ELAPSED_W] ? '1 : esum[rrqs_pkg::ELAPSED_W-1:0];
            n_nxt       = cnt_r;
            keep_nxt    = '0;
            idx_nxt     = '0;
            state_nxt   = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          tag_nxt  = mem_rd.tag;
          last_nxt = fin;
          if (mem_rd.ticks <= quantum) begin
            status_nxt = rrqs_pkg::ST_FINISHED;
            tleft_nxt  = '0;
          end else begin
            // survivor slides down to the next compacted slot
            status_nxt    = rrqs_pkg::ST_RUNNING;
            tleft_nxt     = nt;
            mem_req.we    = 1'b1;
            mem_req.waddr = keep_r[rrqs_pkg::IDX_W-1:0];
            mem_req.wdata = '{tag: mem_rd.tag, ticks: nt};
            keep_nxt      = keep_r + rrqs_pkg::CNT_W'(1);
          end
          if (fin) begin
            cnt_nxt   = keep_nxt;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + rrqs_pkg::IDX_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      n_r         <= '0;
      keep_r      <= '0;
      cnt_r       <= '0;
      rounds_r    <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      keep_r      <= keep_nxt;
      cnt_r       <= cnt_nxt;
      rounds_r    <= rounds_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= status_nxt;
      tag_r    <= tag_nxt;
      tleft_r  <= tleft_nxt;
      round_r  <= round_nxt;
      etot_r   <= etot_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_tag_out       = tag_r;
  assign out_time_left     = tleft_r;
  assign out_round_number  = round_r;
  assign out_elapsed_total = etot_r;
  assign out_last          = last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rrqs_pkg::CNT_W'(rrqs_pkg::MAX_PROCS))
    else $error("table count above depth");

  a_keep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (keep_r <= n_r && rrqs_pkg::CNT_W'(idx_r) < n_r))
    else $error("compaction index out of step with round size");

  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == rrqs_pkg::MODE_RUN && cnt_r != '0) |=> (state_r == S_READ))
    else $error("round did not start");

  a_rounds_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (rounds_r >= $past(rounds_r) && elapsed_r >= $past(elapsed_r)))
    else $error("round counters went backwards");

endmodule

// ===== hdl/round_robin_quantum_scheduler_unit.sv =====
// Top level of the round-robin quantum scheduler: quantum register, sequencer and table.
//
// Usage:
//   Input words (in_valid/in_ready) carry in_mode, in_process_id, in_burst_time.
//   Mode add appends a process unless its burst does not exceed the quantum or
//   the table is full; it yields one result word. Mode run charges one quantum
//   to every entry in order, drops finished ones and compacts the rest; it
//   yields one result word per entry (out_last on the final one), or a single
//   empty-table word when nothing is queued.
//   cfg_we/cfg_wdata writes the quantum; write it only while the block is idle.
// Sequencing:
//   Add and empty run: the result word is registered on accept, and the next
//   word can be accepted as soon as that result is taken. Run over n entries:
//   each entry is a table read (S_READ), then modify and write back (S_EMIT);
//   no new word is accepted before the round's last result is taken. The
//   registered table read is why each entry needs its own read state.
// Reset: table empty, round and elapsed counters zero, quantum 1.
// Stall: a held result blocks further results and new input words; nothing
//   is dropped.
module round_robin_quantum_scheduler_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rrqs_pkg::TIME_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [rrqs_pkg::TAG_W-1:0]        in_process_id,
  input  logic [rrqs_pkg::TIME_W-1:0]       in_burst_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rrqs_pkg::STATUS_W-1:0]     out_status,
  output logic [rrqs_pkg::TAG_W-1:0]        out_tag_out,
  output logic [rrqs_pkg::TIME_W-1:0]       out_time_left,
  output logic [rrqs_pkg::ROUND_W-1:0]      out_round_number,
  output logic [rrqs_pkg::ELAPSED_W-1:0]    out_elapsed_total,
  output logic                              out_last
);

  logic [rrqs_pkg::TIME_W-1:0] quantum_r;
  rrqs_pkg::mem_req_t          mem_req;
  rrqs_pkg::entry_t            mem_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= rrqs_pkg::TIME_W'(1);
    end else if (cfg_we) begin
      quantum_r <= cfg_wdata;
    end
  end

  rrqs_slot_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  rrqs_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .quantum           (quantum_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_process_id     (in_process_id),
    .in_burst_time     (in_burst_time),
    .mem_req           (mem_req),
    .mem_rd            (mem_rd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_tag_out       (out_tag_out),
    .out_time_left     (out_time_left),
    .out_round_number  (out_round_number),
    .out_elapsed_total (out_elapsed_total),
    .out_last          (out_last)
  );

endmodule
